[design/ntoa_pkg.sv]
// Shared types, codes and character tables for the number-to-ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none
package ntoa_pkg;

  typedef enum logic [2:0] {
    CMD_HEX8  = 3'd0,
    CMD_HEX16 = 3'd1,
    CMD_HEX32 = 3'd2,
    CMD_UDEC  = 3'd3,
    CMD_SDEC  = 3'd4,
    CMD_RAW   = 3'd5
  } ntoa_cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } ntoa_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } ntoa_out_t;

  // Character offered by the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] char_out;
    logic       last;
  } ntoa_emit_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam int DecDigits = 4;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {4'd0, nib};
    end else begin
      hex_char = CH_A + {4'd0, nib - 4'd10};
    end
  endfunction

  function automatic logic [15:0] dec_weight(input logic [1:0] k);
    case (k)
      2'd0:    dec_weight = 16'd10000;
      2'd1:    dec_weight = 16'd1000;
      2'd2:    dec_weight = 16'd100;
      default: dec_weight = 16'd10;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/ntoa_sub.sv]
// Shared 16-bit subtract-and-compare unit.
`timescale 1ns / 1ps
`default_nettype none
module ntoa_sub (
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [15:0] diff,
  output logic             ge
);
  logic [16:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[15:0];
  assign ge   = ~wide[16];
endmodule
`default_nettype wire

[design/ntoa_seq.sv]
// Formatting sequencer: prefix, hex and decimal digits, sign, raw characters.
`timescale 1ns / 1ps
`default_nettype none
module ntoa_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ntoa_pkg::ntoa_in_t item,
  input  wire logic              slot_free,
  output logic                   busy,
  output ntoa_pkg::ntoa_emit_t   emit
);
  import ntoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE0, S_PREX, S_HEX, S_SIGN, S_DEC, S_LAST, S_RAW
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] rest_r, rest_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic        started_r, started_nxt;

  logic [15:0] op_a, op_b, diff;
  logic        ge;

  ntoa_sub u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  always_comb begin
    if (state_r == S_SIGN) begin
      op_a = 16'd0;
      op_b = rest_r;
    end else begin
      op_a = rest_r;
      op_b = dec_weight(k_r);
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    emit = '0;
    case (state_r)
      S_PRE0: begin
        emit.valid = 1'b1;
        emit.char_out = CH_ZERO;
      end
      S_PREX: begin
        emit.valid = 1'b1;
        emit.char_out = CH_X;
      end
      S_HEX: begin
        emit.valid = 1'b1;
        emit.char_out = hex_char(shift_r[31:28]);
        emit.last = (cnt_r == 4'd1);
      end
      S_SIGN: begin
        emit.valid = 1'b1;
        emit.char_out = CH_MINUS;
      end
      S_DEC: begin
        emit.valid = ~ge & started_r;
        emit.char_out = CH_ZERO + {4'd0, digit_r};
      end
      S_LAST: begin
        emit.valid = 1'b1;
        emit.char_out = CH_ZERO + {4'd0, rest_r[3:0]};
        emit.last = 1'b1;
      end
      S_RAW: begin
        emit.valid = 1'b1;
        emit.char_out = shift_r[7:0];
        emit.last = 1'b1;
      end
      default: emit = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    rest_nxt    = rest_r;
    k_nxt       = k_r;
    digit_nxt   = digit_r;
    started_nxt = started_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          shift_nxt   = item.value;
          rest_nxt    = item.value[15:0];
          k_nxt       = 2'd0;
          digit_nxt   = 4'd0;
          started_nxt = 1'b0;
          case (item.cmd)
            CMD_HEX8: begin
              shift_nxt = {item.value[7:0], 24'd0};
              cnt_nxt   = 4'd2;
              state_nxt = S_PRE0;
            end
            CMD_HEX16: begin
              shift_nxt = {item.value[15:0], 16'd0};
              cnt_nxt   = 4'd4;
              state_nxt = S_PRE0;
            end
            CMD_HEX32: begin
              cnt_nxt   = 4'd8;
              state_nxt = S_PRE0;
            end
            CMD_UDEC: state_nxt = S_DEC;
            CMD_SDEC: state_nxt = item.value[15] ? S_SIGN : S_DEC;
            CMD_RAW:  state_nxt = S_RAW;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_PRE0: if (slot_free) state_nxt = S_PREX;
      S_PREX: if (slot_free) state_nxt = S_HEX;
      S_HEX: begin
        if (slot_free) begin
          shift_nxt = {shift_r[27:0], 4'd0};
          cnt_nxt   = cnt_r - 4'd1;
          if (cnt_r == 4'd1) state_nxt = S_IDLE;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          rest_nxt  = diff;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (ge) begin
          rest_nxt    = diff;
          digit_nxt   = digit_r + 4'd1;
          started_nxt = 1'b1;
        end else if (!started_r || slot_free) begin
          digit_nxt = 4'd0;
          k_nxt     = k_r + 2'd1;
          if (k_r == 2'(DecDigits - 1)) state_nxt = S_LAST;
        end
      end
      S_LAST: if (slot_free) state_nxt = S_IDLE;
      S_RAW:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    shift_r   <= shift_nxt;
    cnt_r     <= cnt_nxt;
    rest_r    <= rest_nxt;
    k_r       <= k_nxt;
    digit_r   <= digit_nxt;
    started_r <= started_nxt;
  end
endmodule
`default_nettype wire

[design/number_to_ascii_formatter_unit.sv]
// Top level of the number-to-ASCII formatter: input handshake and output register.
// One transaction in yields 0 to 10 character transactions out, one per cycle at best.
// The sequencer stays busy through the 0x prefix and each hex digit, the raw character,
// or each decimal subtraction, weight step and units digit, plus any minus sign;
// output stalls lengthen a transaction.
// The input is stalled until the final character is in the output register.
// Synchronous active-low reset empties the output register and idles the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module number_to_ascii_formatter_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ntoa_pkg::ntoa_in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ntoa_pkg::ntoa_out_t     out_data
);
  import ntoa_pkg::*;

  logic       busy;
  logic       slot_free;
  ntoa_emit_t emit;
  logic       out_valid_r, out_valid_nxt;
  ntoa_out_t  out_data_r, out_data_nxt;

  // Hold new transactions off while a number is still being formatted
  assign in_stall = busy;

  // The output register may take a character when empty or being drained
  assign slot_free = ~out_valid_r | ~out_stall;

  ntoa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid & ~busy),
    .item      (in_data),
    .slot_free (slot_free),
    .busy      (busy),
    .emit      (emit)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      // Load the next character, or drop the taken one
      out_valid_nxt = emit.valid;
      if (emit.valid) begin
        out_data_nxt.char_out = emit.char_out;
        out_data_nxt.last     = emit.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

[design/ntoa_checker.sv]
// Port-level checks for the number-to-ASCII formatter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ntoa_port_checks (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire ntoa_pkg::ntoa_in_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ntoa_pkg::ntoa_out_t out_data
);
  import ntoa_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd <= 3'd5) |=> in_stall)
    else $error("defined command accepted but input not stalled");

  a_text_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open while text unfinished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");
endmodule

bind number_to_ascii_formatter_unit ntoa_port_checks u_ntoa_port_checks (.*);
`default_nettype wire

[tb/ntoa_checker.sv]
// Scoreboard for the number formatter: predicts each character and checks the results.
`timescale 1ns / 1ps
module ntoa_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire ntoa_pkg::ntoa_in_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire ntoa_pkg::ntoa_out_t out_data,
  output int                       errors,
  output int                       outstanding
);
  import ntoa_pkg::*;

  ntoa_out_t expected_chars[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic void add_char(input logic [7:0] c);
    ntoa_out_t ch;
    ch.char_out = c;
    ch.last     = 1'b0;
    expected_chars.push_back(ch);
  endfunction

  function automatic void add_hex(input logic [31:0] v, input int digits);
    logic [3:0] nib;
    add_char(CH_ZERO);
    add_char(CH_X);
    for (int i = digits - 1; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) begin
        add_char(CH_ZERO + {4'd0, nib});
      end else begin
        add_char(CH_A + {4'd0, nib} - 8'd10);
      end
    end
  endfunction

  // Leading zeros dropped, units digit always present
  function automatic void add_decimal(input logic [15:0] mag);
    int unsigned rest;
    int unsigned scale;
    int unsigned digit;
    logic        started;
    rest    = mag;
    scale   = 10000;
    started = 1'b0;
    while (scale >= 10) begin
      digit = rest / scale;
      rest  = rest % scale;
      if (digit != 0) begin
        started = 1'b1;
      end
      if (started) begin
        add_char(CH_ZERO + 8'(digit));
      end
      scale = scale / 10;
    end
    add_char(CH_ZERO + 8'(rest));
  endfunction

  function automatic void format_number(input ntoa_in_t item);
    int        prior_size;
    ntoa_out_t tail;
    prior_size = expected_chars.size();
    case (item.cmd)
      CMD_HEX8:  add_hex({24'd0, item.value[7:0]}, 2);
      CMD_HEX16: add_hex({16'd0, item.value[15:0]}, 4);
      CMD_HEX32: add_hex(item.value, 8);
      CMD_UDEC:  add_decimal(item.value[15:0]);
      CMD_SDEC: begin
        if (item.value[15]) begin
          add_char(CH_MINUS);
          add_decimal(~item.value[15:0] + 16'd1);
        end else begin
          add_decimal(item.value[15:0]);
        end
      end
      CMD_RAW:   add_char(item.value[7:0]);
      default:   ;
    endcase
    if (expected_chars.size() > prior_size) begin
      tail      = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    ntoa_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("char_out %h (last %b) arrived with nothing expected",
                 out_data.char_out, out_data.last);
          errors = errors + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_out !== want.char_out) begin
            $error("char_out: expected %h, got %h", want.char_out, out_data.char_out);
            errors = errors + 1;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        format_number(in_data);
      end
      outstanding = expected_chars.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the formatter testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import ntoa_pkg::*;

  // Command codes the block has no format for; it must swallow them silently
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int RandomItems = 105;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  ntoa_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  ntoa_out_t out_data;

  int errors;
  int outstanding;

  // Odds in percent of a sender gap before a send and of a receiver stall
  int send_idle_pct;
  int recv_stall_pct;

  number_to_ascii_formatter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ntoa_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive every input to a known value before the first edge
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    out_stall      <= 1'b0;
    send_idle_pct  = 37;
    recv_stall_pct = 51;
  end

  // Receiver back-pressure: a fresh coin toss each cycle, so stalls land on
  // the prefix, the digits and the final character alike
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic ntoa_in_t number_item(input logic [2:0] cmd, input logic [31:0] value);
    ntoa_in_t item;
    item.cmd   = cmd;
    item.value = value;
    return item;
  endfunction

  // Random transaction: mostly valid formats, a sprinkle of spare codes, and
  // values biased towards the sign boundary and the decimal carries
  function automatic ntoa_in_t random_number();
    ntoa_in_t    item;
    logic [31:0] noise;
    int          pick;
    noise = $urandom();
    pick  = $urandom_range(0, 99);
    if (pick < 4) begin
      item.cmd = CMD_SPARE6;
    end else if (pick < 8) begin
      item.cmd = CMD_SPARE7;
    end else begin
      item.cmd = 3'($urandom_range(0, 5));
    end
    case ($urandom_range(0, 9))
      5: item.value = {noise[31:16], 16'($urandom_range(0, 20))};
      6: begin
        case ($urandom_range(0, 4))
          0:       item.value = {noise[31:16], 16'h8000};
          1:       item.value = {noise[31:16], 16'h7FFF};
          2:       item.value = {noise[31:16], 16'hFFFF};
          3:       item.value = {noise[31:16], 16'h8001};
          default: item.value = {noise[31:16], 16'h0000};
        endcase
      end
      7: begin
        // Just around a power of ten, where a digit rolls over
        case ($urandom_range(0, 3))
          0:       item.value = {noise[31:16], 16'(9 + $urandom_range(0, 2))};
          1:       item.value = {noise[31:16], 16'(99 + $urandom_range(0, 2))};
          2:       item.value = {noise[31:16], 16'(999 + $urandom_range(0, 2))};
          default: item.value = {noise[31:16], 16'(9999 + $urandom_range(0, 2))};
        endcase
      end
      default: item.value = noise;
    endcase
    return item;
  endfunction

  // Offer one transaction and hold it until accepted. Valid is dropped only
  // when a gap is wanted, so back-to-back transactions keep it high.
  task automatic send_number(input ntoa_in_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int quota);
    ntoa_in_t item;
    int       counted;
    counted = 0;
    while (counted < quota) begin
      item = random_number();
      // Spare codes produce nothing, so they do not count towards the quota
      if (item.cmd <= CMD_RAW) begin
        counted++;
      end
      send_number(item);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, every format, and the special cases
    send_number(number_item(CMD_HEX8,   32'h0000_0000));
    send_number(number_item(CMD_HEX8,   32'hABCD_EFFF));
    send_number(number_item(CMD_HEX8,   32'h1234_565A));
    send_number(number_item(CMD_HEX16,  32'h0000_0000));
    send_number(number_item(CMD_HEX16,  32'hFFFF_FFFF));
    send_number(number_item(CMD_HEX16,  32'h5555_89AB));
    send_number(number_item(CMD_HEX32,  32'h0000_0000));
    send_number(number_item(CMD_HEX32,  32'hFFFF_FFFF));
    send_number(number_item(CMD_HEX32,  32'h0123_4567));
    send_number(number_item(CMD_HEX32,  32'h89AB_CDEF));
    // Zero in decimal gives a single digit
    send_number(number_item(CMD_UDEC,   32'h0000_0000));
    send_number(number_item(CMD_UDEC,   32'hFFFF_FFFF));
    send_number(number_item(CMD_UDEC,   32'h0000_2710));
    send_number(number_item(CMD_UDEC,   32'hFFFF_0009));
    send_number(number_item(CMD_UDEC,   32'h0000_000A));
    // Most negative number: the magnitude only fits as unsigned
    send_number(number_item(CMD_SDEC,   32'h0000_8000));
    send_number(number_item(CMD_SDEC,   32'hFFFF_FFFF));
    send_number(number_item(CMD_SDEC,   32'hFFFF_7FFF));
    send_number(number_item(CMD_SDEC,   32'h0000_0000));
    send_number(number_item(CMD_SDEC,   32'h1234_FF9C));
    send_number(number_item(CMD_RAW,    32'hFFFF_FF00));
    send_number(number_item(CMD_RAW,    32'h0000_00FF));
    send_number(number_item(CMD_RAW,    32'h0000_0041));
    // Undefined commands are dropped without output
    send_number(number_item(CMD_SPARE6, 32'hFFFF_FFFF));
    send_number(number_item(CMD_SPARE7, 32'h0000_0000));

    send_random(44);

    // Swap the idling: the sender gets sluggish, the receiver keeps up better
    send_idle_pct  = 51;
    recv_stall_pct = 37;
    send_random(43);

    // Full throughput on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random(RandomItems - 44 - 43);

    in_valid <= 1'b0;

    // Drain the text still in flight, then give the block time to show any
    // stray character
    do @(negedge clk); while (outstanding != 0);
    repeat (40) @(negedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
design/ntoa_pkg.sv
design/ntoa_sub.sv
design/ntoa_seq.sv
design/number_to_ascii_formatter_unit.sv
design/ntoa_checker.sv
tb/ntoa_checker.sv
tb/testbench.sv
